/* rtl/core/smw_pkg.sv */
// ----------------------------------------------------------------------------
// smw_pkg: shared types and constants of the stuck multiplexer watchdog
// Holds register indexes, reset values, the config bundle and queue entry.
// ----------------------------------------------------------------------------
package smw_pkg;

  localparam int unsigned SMW_MAX_GROUPS   = 8;
  localparam int unsigned SMW_MAX_CHANNELS = 8;
  localparam int unsigned SMW_QUEUE_DEPTH  = 2;

  localparam int unsigned SMW_IDX_W    = 3;
  localparam int unsigned SMW_TIME_W   = 32;
  localparam int unsigned SMW_SAMPLE_W = 16;
  localparam int unsigned SMW_BITMAP_W = 8;
  localparam int unsigned SMW_COUNT_W  = 4;
  localparam int unsigned SMW_ADDR_W   = 5;
  localparam int unsigned SMW_DATA_W   = 32;

  localparam logic [SMW_COUNT_W-1:0]  SMW_RST_MUXES    = 4'd8;
  localparam logic [SMW_COUNT_W-1:0]  SMW_RST_CHANNELS = 4'd8;
  localparam logic [SMW_TIME_W-1:0]   SMW_RST_LIMIT    = 32'd1000;
  localparam logic [SMW_SAMPLE_W-1:0] SMW_RST_LOW      = 16'd0;
  localparam logic [SMW_SAMPLE_W-1:0] SMW_RST_HIGH     = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_MUXES_IN_USE    = 3'd0,
    REG_CHANNELS_IN_USE = 3'd1,
    REG_STUCK_TIME      = 3'd2,
    REG_LOW_RAIL        = 3'd3,
    REG_HIGH_RAIL       = 3'd4
  } smw_reg_e;

  typedef logic [SMW_SAMPLE_W-1:0] smw_sample_t;

  typedef struct packed {
    logic [SMW_COUNT_W-1:0]  muxes_in_use;
    logic [SMW_COUNT_W-1:0]  channels_in_use;
    logic [SMW_TIME_W-1:0]   stuck_time_limit;
    logic [SMW_SAMPLE_W-1:0] low_rail_limit;
    logic [SMW_SAMPLE_W-1:0] high_rail_limit;
  } smw_cfg_t;

  // One classified scan on its way to the state update
  typedef struct packed {
    logic                    update;
    logic                    lanes_match;
    logic                    extreme;
    logic [SMW_IDX_W-1:0]    idx;
    logic [SMW_TIME_W-1:0]   time_ms;
    logic [SMW_SAMPLE_W-1:0] first;
  } smw_entry_t;

endpackage

/* rtl/core/smw_front.sv */
// ----------------------------------------------------------------------------
// smw_front: scan classifier
// Compares the enabled channels against channel 0, checks the rail limits
// and decides whether the scan may touch its group's state.
// ----------------------------------------------------------------------------
module smw_front import smw_pkg::*; #(
  parameter int unsigned MAX_GROUPS = SMW_MAX_GROUPS
) (
  input  smw_cfg_t               cfg_i,
  input  logic [SMW_IDX_W-1:0]   mux_index_i,
  input  logic [SMW_TIME_W-1:0]  time_ms_i,
  input  smw_sample_t            samples_i [SMW_MAX_CHANNELS],
  output smw_entry_t             entry_o
);

  logic lanes_match;
  logic in_range;

  always_comb begin
    lanes_match = 1'b1;
    for (int unsigned k = 1; k < SMW_MAX_CHANNELS; k++) begin
      if ((SMW_COUNT_W'(k) < cfg_i.channels_in_use) && (samples_i[k] != samples_i[0])) begin
        lanes_match = 1'b0;
      end
    end
  end

  assign in_range = ({1'b0, mux_index_i} < cfg_i.muxes_in_use) &&
                    ({1'b0, mux_index_i} < SMW_COUNT_W'(MAX_GROUPS));

  always_comb begin
    entry_o.update      = in_range && (cfg_i.channels_in_use != '0);
    entry_o.lanes_match = lanes_match;
    entry_o.extreme     = (samples_i[0] <= cfg_i.low_rail_limit) ||
                          (samples_i[0] >= cfg_i.high_rail_limit);
    entry_o.idx         = mux_index_i;
    entry_o.time_ms     = time_ms_i;
    entry_o.first       = samples_i[0];
  end

endmodule

/* rtl/core/smw_queue.sv */
// ----------------------------------------------------------------------------
// smw_queue: short queue between classifier and state update
// Small FIFO of classified items; full stalls the input side.
// ----------------------------------------------------------------------------
module smw_queue import smw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  smw_entry_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output smw_entry_t rdata_o
);

  localparam int unsigned PtrW = (SMW_QUEUE_DEPTH > 1) ? $clog2(SMW_QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(SMW_QUEUE_DEPTH + 1);

  smw_entry_t          mem_q [SMW_QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    if (ptr == PtrW'(SMW_QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(SMW_QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/smw_back.sv */
// ----------------------------------------------------------------------------
// smw_back: per-group run tracking and result register
// Updates run and dead marks of one group per item and registers the result.
// ----------------------------------------------------------------------------
module smw_back import smw_pkg::*; #(
  parameter int unsigned MAX_GROUPS = SMW_MAX_GROUPS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smw_cfg_t                cfg_i,
  input  logic                    q_valid_i,
  input  smw_entry_t              q_entry_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SMW_BITMAP_W-1:0] dead_bitmap_o,
  output logic                    group_is_dead_o,
  output logic                    any_group_dead_o,
  output logic                    group_run_active_o
);

  localparam int unsigned GidxW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic [MAX_GROUPS-1:0]   active_q, active_d;
  logic [MAX_GROUPS-1:0]   dead_q, dead_d;
  logic [SMW_TIME_W-1:0]   start_q [MAX_GROUPS];
  logic [SMW_SAMPLE_W-1:0] value_q [MAX_GROUPS];

  logic                    out_valid_q;
  logic [SMW_BITMAP_W-1:0] bitmap_q, bitmap_d;
  logic                    grp_dead_q, grp_active_q, any_q;

  logic                    in_grp;
  logic [GidxW-1:0]        gi;
  logic                    restart;
  logic                    write_run;
  logic [SMW_TIME_W-1:0]   start_new;
  logic [SMW_SAMPLE_W-1:0] value_new;
  logic [SMW_TIME_W-1:0]   elapsed;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign in_grp = ({1'b0, q_entry_i.idx} < SMW_COUNT_W'(MAX_GROUPS));
  assign gi     = in_grp ? q_entry_i.idx[GidxW-1:0] : '0;

  assign restart = !active_q[gi] || (value_q[gi] != q_entry_i.first);
  assign elapsed = q_entry_i.time_ms - (restart ? q_entry_i.time_ms : start_q[gi]);

  always_comb begin
    active_d  = active_q;
    dead_d    = dead_q;
    write_run = 1'b0;
    start_new = '0;
    value_new = '0;
    if (q_pop_o && q_entry_i.update) begin
      if (q_entry_i.lanes_match) begin
        active_d[gi] = 1'b1;
        if (restart) begin
          write_run = 1'b1;
          start_new = q_entry_i.time_ms;
          value_new = q_entry_i.first;
        end
        if ((elapsed >= cfg_i.stuck_time_limit) && q_entry_i.extreme) begin
          dead_d[gi] = 1'b1;
        end
      end else begin
        // differing channel: drop the run and the dead mark
        active_d[gi] = 1'b0;
        dead_d[gi]   = 1'b0;
        write_run    = 1'b1;
      end
    end
  end

  always_comb begin
    bitmap_d = '0;
    for (int unsigned g = 0; g < MAX_GROUPS; g++) begin
      bitmap_d[g] = dead_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      dead_q       <= '0;
      out_valid_q  <= 1'b0;
      bitmap_q     <= '0;
      grp_dead_q   <= 1'b0;
      grp_active_q <= 1'b0;
      any_q        <= 1'b0;
      for (int unsigned g = 0; g < MAX_GROUPS; g++) begin
        start_q[g] <= '0;
        value_q[g] <= '0;
      end
    end else begin
      active_q <= active_d;
      dead_q   <= dead_d;
      if (write_run) begin
        start_q[gi] <= start_new;
        value_q[gi] <= value_new;
      end
      if (q_pop_o) begin
        out_valid_q  <= 1'b1;
        bitmap_q     <= bitmap_d;
        grp_dead_q   <= in_grp && dead_d[gi];
        grp_active_q <= in_grp && active_d[gi];
        any_q        <= (dead_d != '0);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign dead_bitmap_o      = bitmap_q;
  assign group_is_dead_o    = grp_dead_q;
  assign any_group_dead_o   = any_q;
  assign group_run_active_o = grp_active_q;

  a_dead_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dead_q & ~active_q) == '0)
    else $error("group marked dead without an active run");

  a_mismatch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_entry_i.update && !q_entry_i.lanes_match
    |=> !group_is_dead_o && !group_run_active_o)
    else $error("differing scan left run or dead mark set");

  a_equal_sets_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_entry_i.update && q_entry_i.lanes_match |=> group_run_active_o)
    else $error("equal scan did not leave run active");

  a_ignored_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && !q_entry_i.update |=> $stable(active_q) && $stable(dead_q))
    else $error("ignored item changed group state");

endmodule

/* rtl/core/stuck_mux_watchdog.sv */
// ----------------------------------------------------------------------------
// stuck_mux_watchdog: detects multiplexer groups whose channels stick at a rail
// Classifier feeds a two-entry queue; the state update registers one result
// per item. Each accepted item passes through the queue and then the result
// register before its result is offered.
// Throughput: one item per cycle while the output is not stalled.
// Reset clears all per-group marks, the queue and restores register defaults.
// ----------------------------------------------------------------------------
module stuck_mux_watchdog import smw_pkg::*; #(
  parameter int unsigned MAX_GROUPS = SMW_MAX_GROUPS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [SMW_ADDR_W-1:0]   paddr,
  input  logic [SMW_DATA_W-1:0]   pwdata,
  output logic [SMW_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SMW_IDX_W-1:0]    mux_index_i,
  input  logic [SMW_TIME_W-1:0]   time_ms_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_0_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_1_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_2_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_3_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_4_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_5_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_6_i,
  input  logic [SMW_SAMPLE_W-1:0] sample_7_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SMW_BITMAP_W-1:0] dead_bitmap_o,
  output logic                    group_is_dead_o,
  output logic                    any_group_dead_o,
  output logic                    group_run_active_o
);

  smw_cfg_t    cfg_q;
  smw_sample_t samples [SMW_MAX_CHANNELS];
  smw_entry_t  front_entry;
  smw_entry_t  q_entry;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;
  logic        reg_wr;
  smw_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = smw_reg_e'(paddr[SMW_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.muxes_in_use     <= SMW_RST_MUXES;
      cfg_q.channels_in_use  <= SMW_RST_CHANNELS;
      cfg_q.stuck_time_limit <= SMW_RST_LIMIT;
      cfg_q.low_rail_limit   <= SMW_RST_LOW;
      cfg_q.high_rail_limit  <= SMW_RST_HIGH;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_MUXES_IN_USE:    cfg_q.muxes_in_use     <= pwdata[SMW_COUNT_W-1:0];
        REG_CHANNELS_IN_USE: cfg_q.channels_in_use  <= pwdata[SMW_COUNT_W-1:0];
        REG_STUCK_TIME:      cfg_q.stuck_time_limit <= pwdata[SMW_TIME_W-1:0];
        REG_LOW_RAIL:        cfg_q.low_rail_limit   <= pwdata[SMW_SAMPLE_W-1:0];
        REG_HIGH_RAIL:       cfg_q.high_rail_limit  <= pwdata[SMW_SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MUXES_IN_USE:    prdata = SMW_DATA_W'(cfg_q.muxes_in_use);
      REG_CHANNELS_IN_USE: prdata = SMW_DATA_W'(cfg_q.channels_in_use);
      REG_STUCK_TIME:      prdata = SMW_DATA_W'(cfg_q.stuck_time_limit);
      REG_LOW_RAIL:        prdata = SMW_DATA_W'(cfg_q.low_rail_limit);
      REG_HIGH_RAIL:       prdata = SMW_DATA_W'(cfg_q.high_rail_limit);
      default:             prdata = '0;
    endcase
  end

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  smw_front #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .cfg_i       (cfg_q),
    .mux_index_i (mux_index_i),
    .time_ms_i   (time_ms_i),
    .samples_i   (samples),
    .entry_o     (front_entry)
  );

  smw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_entry)
  );

  smw_back #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .q_entry_i          (q_entry),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .dead_bitmap_o      (dead_bitmap_o),
    .group_is_dead_o    (group_is_dead_o),
    .any_group_dead_o   (any_group_dead_o),
    .group_run_active_o (group_run_active_o)
  );

endmodule

/* verif/stuck_mux_watchdog_tb.sv */
// ----------------------------------------------------------------------------
// stuck_mux_watchdog_tb: self-checking bench for the stuck multiplexer watchdog
// Runs a table of directed scans and register writes, then random phases of
// equal runs, level changes and noise under several settings. Results are
// checked against table verdicts or an in-bench model of group run and dead marks.
// ----------------------------------------------------------------------------
module stuck_mux_watchdog_tb;
  import smw_pkg::*;

  typedef struct packed {
    logic [SMW_IDX_W-1:0]         idx;
    logic [SMW_TIME_W-1:0]        time_ms;
    logic [7:0][SMW_SAMPLE_W-1:0] samples;
  } scan_t;

  typedef struct packed {
    logic [SMW_BITMAP_W-1:0] dead_bitmap;
    logic                    group_is_dead;
    logic                    any_group_dead;
    logic                    group_run_active;
  } verdict_t;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    smw_reg_e  reg_sel;
    logic [31:0] value;
    scan_t     scan;
    logic      typed;
    verdict_t  want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [SMW_ADDR_W-1:0] paddr = '0;
  logic [SMW_DATA_W-1:0] pwdata = '0;
  logic [SMW_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SMW_IDX_W-1:0] mux_index_i = '0;
  logic [SMW_TIME_W-1:0] time_ms_i = '0;
  logic [SMW_SAMPLE_W-1:0] sample_0_i = '0, sample_1_i = '0, sample_2_i = '0;
  logic [SMW_SAMPLE_W-1:0] sample_3_i = '0, sample_4_i = '0, sample_5_i = '0;
  logic [SMW_SAMPLE_W-1:0] sample_6_i = '0, sample_7_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SMW_BITMAP_W-1:0] dead_bitmap_o;
  logic group_is_dead_o;
  logic any_group_dead_o;
  logic group_run_active_o;

  stuck_mux_watchdog dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mux_index_i(mux_index_i), .time_ms_i(time_ms_i),
    .sample_0_i(sample_0_i), .sample_1_i(sample_1_i), .sample_2_i(sample_2_i),
    .sample_3_i(sample_3_i), .sample_4_i(sample_4_i), .sample_5_i(sample_5_i),
    .sample_6_i(sample_6_i), .sample_7_i(sample_7_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .dead_bitmap_o(dead_bitmap_o), .group_is_dead_o(group_is_dead_o),
    .any_group_dead_o(any_group_dead_o), .group_run_active_o(group_run_active_o)
  );

  // Model state: settings and per-group run tracking
  smw_cfg_t shadow_cfg;
  logic [SMW_MAX_GROUPS-1:0] run_on;
  logic [SMW_MAX_GROUPS-1:0] dead_marks;
  logic [SMW_TIME_W-1:0]     run_since [SMW_MAX_GROUPS];
  logic [SMW_SAMPLE_W-1:0]   run_level [SMW_MAX_GROUPS];

  verdict_t pending_verdicts[$];
  verdict_t seen_want;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 300000);
    $display("stuck_mux_watchdog_tb: errors");
    $finish;
  end

  function automatic verdict_t predict_scan_verdict(scan_t s);
    int unsigned groups;
    int unsigned lanes;
    logic lanes_match;
    logic [SMW_TIME_W-1:0] elapsed;
    logic [SMW_SAMPLE_W-1:0] first;
    verdict_t v;
    groups = (shadow_cfg.muxes_in_use > SMW_MAX_GROUPS) ? SMW_MAX_GROUPS
                                                        : shadow_cfg.muxes_in_use;
    lanes = (shadow_cfg.channels_in_use > SMW_MAX_CHANNELS) ? SMW_MAX_CHANNELS
                                                            : shadow_cfg.channels_in_use;
    first = s.samples[0];
    if (s.idx < groups && lanes > 0) begin
      lanes_match = 1'b1;
      for (int k = 1; k < lanes; k++) begin
        if (s.samples[k] != first) lanes_match = 1'b0;
      end
      if (lanes_match) begin
        // restart the run on a fresh start or a new common level
        if (!run_on[s.idx] || run_level[s.idx] != first) begin
          run_on[s.idx] = 1'b1;
          run_since[s.idx] = s.time_ms;
          run_level[s.idx] = first;
        end
        elapsed = s.time_ms - run_since[s.idx];
        if (elapsed >= shadow_cfg.stuck_time_limit &&
            (first <= shadow_cfg.low_rail_limit || first >= shadow_cfg.high_rail_limit))
          dead_marks[s.idx] = 1'b1;
      end else begin
        run_on[s.idx] = 1'b0;
        run_since[s.idx] = '0;
        run_level[s.idx] = '0;
        dead_marks[s.idx] = 1'b0;
      end
    end
    v.dead_bitmap = dead_marks;
    v.group_is_dead = dead_marks[s.idx];
    v.any_group_dead = |dead_marks;
    v.group_run_active = run_on[s.idx];
    return v;
  endfunction

  function automatic int unsigned next_gap();
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 30);
    return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  function automatic logic [SMW_SAMPLE_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return shadow_cfg.low_rail_limit;
      3: return shadow_cfg.high_rail_limit;
      4: return shadow_cfg.low_rail_limit + 1'b1;
      5: return shadow_cfg.high_rail_limit - 1'b1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic plan_row_t scan_row(logic [2:0] idx, logic [31:0] t,
                                         logic [7:0][15:0] samples,
                                         logic typed, verdict_t want);
    plan_row_t r;
    r.kind = ROW_SCAN;
    r.reg_sel = REG_MUXES_IN_USE;
    r.value = '0;
    r.scan = '{idx: idx, time_ms: t, samples: samples};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(smw_reg_e sel, logic [31:0] value);
    plan_row_t r;
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.value = value;
    r.scan = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Drop valid, then hold until every expected item has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(smw_reg_e sel, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_MUXES_IN_USE:    shadow_cfg.muxes_in_use = value[3:0];
      REG_CHANNELS_IN_USE: shadow_cfg.channels_in_use = value[3:0];
      REG_STUCK_TIME:      shadow_cfg.stuck_time_limit = value;
      REG_LOW_RAIL:        shadow_cfg.low_rail_limit = value[15:0];
      REG_HIGH_RAIL:       shadow_cfg.high_rail_limit = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Returns at the rising edge where the item is taken
  task automatic send_scan(scan_t s, int unsigned gap, logic typed, verdict_t want);
    verdict_t v;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mux_index_i <= s.idx;
    time_ms_i <= s.time_ms;
    sample_0_i <= s.samples[0];
    sample_1_i <= s.samples[1];
    sample_2_i <= s.samples[2];
    sample_3_i <= s.samples[3];
    sample_4_i <= s.samples[4];
    sample_5_i <= s.samples[5];
    sample_6_i <= s.samples[6];
    sample_7_i <= s.samples[7];
    do @(posedge clk_i); while (in_stall_o);
    v = predict_scan_verdict(s);
    pending_verdicts.push_back(typed ? want : v);
  endtask

  // Receiver: switch at random between no stall, light and heavy stall
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(10, 80);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected item, bitmap %0h", $time, dead_bitmap_o);
        error_count++;
      end else begin
        seen_want = pending_verdicts.pop_front();
        report_field("dead_bitmap", 32'(seen_want.dead_bitmap), 32'(dead_bitmap_o));
        report_field("group_is_dead", 32'(seen_want.group_is_dead), 32'(group_is_dead_o));
        report_field("any_group_dead", 32'(seen_want.any_group_dead),
                     32'(any_group_dead_o));
        report_field("group_run_active", 32'(seen_want.group_run_active),
                     32'(group_run_active_o));
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    plan_row_t row;
    scan_t s;
    logic [SMW_SAMPLE_W-1:0] level [SMW_MAX_GROUPS];
    logic [31:0] now_ms;
    logic [31:0] step_max;
    logic [3:0] m, c;
    logic [31:0] lim;
    logic [15:0] lo, hi;
    int unsigned lanes, roll, g, k;

    shadow_cfg = '{muxes_in_use: SMW_RST_MUXES, channels_in_use: SMW_RST_CHANNELS,
                   stuck_time_limit: SMW_RST_LIMIT, low_rail_limit: SMW_RST_LOW,
                   high_rail_limit: SMW_RST_HIGH};
    run_on = '0;
    dead_marks = '0;
    for (int i = 0; i < SMW_MAX_GROUPS; i++) begin
      run_since[i] = '0;
      run_level[i] = '0;
      level[i] = '0;
    end

    // Reset-default settings: low rail 0, high rail all ones, 1000 ms debounce
    plan.push_back(scan_row(0, 0, {8{16'h0000}}, 1, {8'h00, 3'b001}));
    plan.push_back(scan_row(0, 999, {8{16'h0000}}, 1, {8'h00, 3'b001}));
    plan.push_back(scan_row(0, 1000, {8{16'h0000}}, 1, {8'h01, 3'b111}));
    plan.push_back(scan_row(1, 5, {8{16'hFFFF}}, 1, {8'h01, 3'b011}));
    plan.push_back(scan_row(1, 1005, {8{16'hFFFF}}, 1, {8'h03, 3'b111}));
    plan.push_back(scan_row(0, 2000, {16'h0001, {7{16'h0000}}}, 1, {8'h02, 3'b010}));
    plan.push_back(scan_row(1, 2000, {8{16'hFFFF}}, 1, {8'h02, 3'b111}));
    // level change restarts the run but keeps the dead mark
    plan.push_back(scan_row(1, 2001, {8{16'hFFFE}}, 1, {8'h02, 3'b111}));
    plan.push_back(scan_row(2, 32'hFFFF_FF00, {8{16'h8000}}, 1, {8'h02, 3'b011}));
    plan.push_back(scan_row(2, 32'h0000_0400, {8{16'h8000}}, 1, {8'h02, 3'b011}));
    // time wraps across zero
    plan.push_back(scan_row(3, 32'hFFFF_FE00, {8{16'h0000}}, 1, {8'h02, 3'b011}));
    plan.push_back(scan_row(3, 32'h0000_01E7, {8{16'h0000}}, 1, {8'h02, 3'b011}));
    plan.push_back(scan_row(3, 32'h0000_01E8, {8{16'h0000}}, 1, {8'h0A, 3'b111}));
    plan.push_back(cfg_row(REG_CHANNELS_IN_USE, 1));
    plan.push_back(scan_row(4, 0, {16'h1111, 16'h2222, 16'h3333, 16'h4444,
                                   16'h5555, 16'h6666, 16'h7777, 16'h1234}, 0, '0));
    plan.push_back(cfg_row(REG_CHANNELS_IN_USE, 0));
    plan.push_back(scan_row(0, 3000, {16'hABCD, {7{16'h0000}}}, 0, '0));
    plan.push_back(cfg_row(REG_CHANNELS_IN_USE, 15));
    plan.push_back(scan_row(4, 5, {{4{16'h1234}}, 16'h1235, {3{16'h1234}}}, 0, '0));
    plan.push_back(cfg_row(REG_MUXES_IN_USE, 2));
    plan.push_back(scan_row(5, 0, {8{16'hFFFF}}, 0, '0));
    plan.push_back(scan_row(1, 2500, {{6{16'hFFFE}}, 16'h0000, 16'hFFFE}, 0, '0));
    plan.push_back(cfg_row(REG_MUXES_IN_USE, 0));
    plan.push_back(scan_row(0, 4000, {{6{16'h0000}}, 16'h0001, 16'h0000}, 0, '0));
    plan.push_back(cfg_row(REG_MUXES_IN_USE, 15));
    plan.push_back(cfg_row(REG_STUCK_TIME, 0));
    plan.push_back(cfg_row(REG_LOW_RAIL, 16'h1000));
    plan.push_back(cfg_row(REG_HIGH_RAIL, 16'h1000));
    // overlapping rails, zero debounce
    plan.push_back(scan_row(6, 7, {8{16'h1000}}, 0, '0));
    plan.push_back(scan_row(7, 8, {8{16'h0FFF}}, 0, '0));
    plan.push_back(scan_row(7, 9, {8{16'h1001}}, 0, '0));
    plan.push_back(cfg_row(REG_STUCK_TIME, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_LOW_RAIL, 16'hFFFF));
    plan.push_back(cfg_row(REG_HIGH_RAIL, 16'h0000));
    plan.push_back(scan_row(5, 10, {8{16'h55AA}}, 0, '0));
    plan.push_back(scan_row(5, 9, {8{16'h55AA}}, 0, '0));
    plan.push_back(scan_row(2, 11, {$urandom, $urandom, $urandom, $urandom}, 0, '0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        apb_write(row.reg_sel, row.value);
      end else begin
        send_scan(row.scan, next_gap(), row.typed, row.want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin m = 8;  c = 8;  lim = 100;  lo = 16'h00FF; hi = 16'hFF00; end
        1: begin m = 1;  c = 1;  lim = 0;    lo = 16'h0000; hi = 16'hFFFF; end
        2: begin m = 15; c = 15; lim = 50;   lo = 16'hFFFF; hi = 16'h0000; end
        3: begin m = 5;  c = 3;  lim = $urandom_range(0, 300);
                 lo = 16'($urandom); hi = 16'($urandom); end
        4: begin m = 8;  c = 8;  lim = 32'h8000_0000; lo = 16'h8000; hi = 16'h8000; end
        default: begin
          m = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(1, 8));
          c = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(1, 8));
          lim = $urandom_range(0, 400);
          lo = 16'($urandom_range(0, 16'h2000));
          hi = 16'($urandom_range(16'hE000, 16'hFFFF));
        end
      endcase
      settle();
      apb_write(REG_MUXES_IN_USE, 32'(m));
      apb_write(REG_CHANNELS_IN_USE, 32'(c));
      apb_write(REG_STUCK_TIME, lim);
      apb_write(REG_LOW_RAIL, 32'(lo));
      apb_write(REG_HIGH_RAIL, 32'(hi));
      lanes = (c > SMW_MAX_CHANNELS) ? SMW_MAX_CHANNELS : c;
      step_max = (lim > 600) ? 200 : lim / 3 + 2;
      now_ms = (p == 1 || p == 3) ? 32'hFFFF_F000 + $urandom_range(0, 2048) : $urandom;
      for (int i = 0; i < SMW_MAX_GROUPS; i++) level[i] = pick_level();

      for (int n = 0; n < 75; n++) begin
        g = $urandom_range(0, 7);
        roll = $urandom_range(0, 99);
        if (roll < 8) level[g] = pick_level();
        if ($urandom_range(0, 19) == 0) now_ms = now_ms + $urandom;
        else now_ms = now_ms + $urandom_range(0, step_max);
        s.idx = 3'(g);
        s.time_ms = now_ms;
        for (k = 0; k < 8; k++) s.samples[k] = (k < lanes) ? level[g] : 16'($urandom);
        if (roll >= 90) begin
          for (k = 0; k < 8; k++) s.samples[k] = 16'($urandom);
        end else if (roll >= 75) begin
          k = $urandom_range(1, 7);
          s.samples[k] = s.samples[k] ^ 16'($urandom_range(1, 65535));
        end
        send_scan(s, next_gap(), 1'b0, '0);
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("stuck_mux_watchdog_tb: clean");
    end else begin
      $display("stuck_mux_watchdog_tb: errors");
    end
    $finish;
  end

endmodule
